@@ rtl/led_fx_pkg.sv @@
// Shared types, codes and helper functions for the LED strip effect engine.
`default_nettype none

package led_fx_pkg;

    localparam int LED_COUNT   = 4;
    localparam int ADDR_W      = (LED_COUNT > 1) ? $clog2(LED_COUNT) : 1;
    // The command queue depth must be a power of two so the pointers wrap.
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    localparam logic [1:0] KIND_TICK      = 2'd0;
    localparam logic [1:0] KIND_WRITE_ONE = 2'd1;
    localparam logic [1:0] KIND_WRITE_ALL = 2'd2;

    localparam int REG_W = 2;
    localparam logic [REG_W-1:0] REG_BRIGHTNESS    = 2'd0;
    localparam logic [REG_W-1:0] REG_EFFECT_MODE   = 2'd1;
    localparam logic [REG_W-1:0] REG_EFFECT_SPEED  = 2'd2;
    localparam logic [REG_W-1:0] REG_STRIP_ENABLED = 2'd3;

    localparam logic [2:0] MODE_STATIC  = 3'd0;
    localparam logic [2:0] MODE_BLINK   = 3'd1;
    localparam logic [2:0] MODE_FADE    = 3'd2;
    localparam logic [2:0] MODE_RAINBOW = 3'd3;
    localparam logic [2:0] MODE_BREATHE = 3'd4;
    localparam logic [2:0] MODE_SCANNER = 3'd5;
    localparam logic [2:0] MODE_RANDOM  = 3'd6;
    localparam logic [2:0] MODE_CHASE   = 3'd7;

    localparam logic [1:0] OP_WRITE_ONE = 2'd0;
    localparam logic [1:0] OP_WRITE_ALL = 2'd1;
    localparam logic [1:0] OP_ADVANCE   = 2'd2;

    localparam logic [7:0] FADE_STEP    = 8'd10;
    localparam logic [7:0] BREATHE_STEP = 8'd5;
    localparam logic [7:0] RAINBOW_STEP = 8'd5;
    localparam logic [7:0] LEVEL_MAX    = 8'd255;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } rgb_t;

    typedef struct packed {
        logic [7:0] brightness;
        logic [2:0] effect_mode;
        logic [3:0] effect_speed;
        logic       strip_enabled;
    } cfg_t;

    typedef struct packed {
        logic [1:0]        op;
        logic [ADDR_W-1:0] index;
        rgb_t              colour;
    } cmd_t;

    typedef struct packed {
        logic [7:0] level;
        logic       falling;
    } bounce_t;

    // Tick interval for a speed setting, with the speed saturated to 1..10.
    function automatic logic [6:0] tick_interval(logic [3:0] speed);
        logic [3:0] sp;
        sp = speed;
        if (speed == 4'd0)
        begin
            sp = 4'd1;
        end
        else if (speed > 4'd10)
        begin
            sp = 4'd10;
        end
        return 7'(7'd100 - 7'(sp) * 7'd10);
    endfunction

    // Three-segment colour wheel with boundaries at 85 and 170.
    function automatic rgb_t wheel(logic [7:0] hue);
        rgb_t       c;
        logic [7:0] h;
        logic [7:0] h3;
        if (hue < 8'd85)
        begin
            h3 = 8'(hue * 8'd3);
            c.red   = h3;
            c.green = LEVEL_MAX - h3;
            c.blue  = 8'd0;
        end
        else if (hue < 8'd170)
        begin
            h  = hue - 8'd85;
            h3 = 8'(h * 8'd3);
            c.red   = LEVEL_MAX - h3;
            c.green = 8'd0;
            c.blue  = h3;
        end
        else
        begin
            h  = hue - 8'd170;
            h3 = 8'(h * 8'd3);
            c.red   = 8'd0;
            c.green = h3;
            c.blue  = LEVEL_MAX - h3;
        end
        return c;
    endfunction

    // c * m / 255, truncated; exact over the whole 16-bit product range.
    function automatic logic [7:0] scale8(logic [7:0] c, logic [7:0] m);
        logic [15:0] p;
        logic [16:0] q;
        p = 16'(c) * 16'(m);
        q = 17'(p) + 17'(p[15:8]) + 17'd1;
        return q[15:8];
    endfunction

    // Level that moves by delta, clamps at 0 and 255 and turns at the ends.
    function automatic bounce_t bounce(logic [7:0] level, logic falling, logic [7:0] delta);
        bounce_t    r;
        logic [8:0] up;
        up = 9'(level) + 9'(delta);
        if (!falling)
        begin
            if (up >= 9'd255)
            begin
                r.level   = LEVEL_MAX;
                r.falling = 1'b1;
            end
            else
            begin
                r.level   = up[7:0];
                r.falling = 1'b0;
            end
        end
        else
        begin
            if (level <= delta)
            begin
                r.level   = 8'd0;
                r.falling = 1'b0;
            end
            else
            begin
                r.level   = level - delta;
                r.falling = 1'b1;
            end
        end
        return r;
    endfunction

endpackage

`default_nettype wire

@@ rtl/led_fx_queue.sv @@
// Short command queue between the request classifier and the frame generator.
`default_nettype none

module led_fx_queue (
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire                 push,
    input  led_fx_pkg::cmd_t    push_cmd,
    output logic                full,
    input  wire                 pop,
    output led_fx_pkg::cmd_t    pop_cmd,
    output logic                empty
);
    import led_fx_pkg::*;

    cmd_t              entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_next;
    logic [QPTR_W:0]   count_reg;
    logic [QPTR_W:0]   count_next;
    logic              do_push;
    logic              do_pop;

    assign full    = (count_reg == (QPTR_W+1)'(QUEUE_DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign pop_cmd = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

`default_nettype wire

@@ rtl/led_fx_front.sv @@
// Request classifier: counts ticks, filters requests and queues frame commands.
`default_nettype none

module led_fx_front (
    input  wire                 clk,
    input  wire                 rst_n,
    input  led_fx_pkg::cfg_t    cfg,
    input  wire                 in_valid,
    output logic                in_stall,
    input  wire  [1:0]          kind,
    input  wire  [7:0]          led_index,
    input  wire  [7:0]          red_in,
    input  wire  [7:0]          green_in,
    input  wire  [7:0]          blue_in,
    output logic                push,
    output led_fx_pkg::cmd_t    push_cmd,
    input  wire                 queue_full
);
    import led_fx_pkg::*;

    logic [6:0] tick_count_reg;
    logic [6:0] tick_count_next;
    logic [6:0] tick_inc;
    logic [6:0] interval;
    logic       accept;

    assign in_stall = queue_full;
    assign accept   = in_valid && !queue_full;
    assign interval = tick_interval(cfg.effect_speed);
    assign tick_inc = tick_count_reg + 7'd1;

    always_comb
    begin
        push                = 1'b0;
        push_cmd.op         = OP_ADVANCE;
        push_cmd.index      = led_index[ADDR_W-1:0];
        push_cmd.colour     = '{red: red_in, green: green_in, blue: blue_in};
        tick_count_next     = tick_count_reg;
        if (accept)
        begin
            case (kind)
                KIND_TICK:
                begin
                    // A disabled strip freezes the tick counter as well as the effects.
                    if (cfg.strip_enabled)
                    begin
                        if (tick_inc < interval)
                        begin
                            tick_count_next = tick_inc;
                        end
                        else
                        begin
                            tick_count_next = 7'd0;
                            push = !(cfg.effect_mode inside {MODE_STATIC, MODE_RANDOM});
                        end
                    end
                end
                KIND_WRITE_ONE:
                begin
                    push_cmd.op = OP_WRITE_ONE;
                    push        = (led_index < 8'(LED_COUNT));
                end
                KIND_WRITE_ALL:
                begin
                    push_cmd.op = OP_WRITE_ALL;
                    push        = 1'b1;
                end
                default:
                begin
                    push = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_count_reg <= 7'd0;
        end
        else
        begin
            tick_count_reg <= tick_count_next;
        end
    end

endmodule

`default_nettype wire

@@ rtl/led_fx_back.sv @@
// Frame generator: effect state, colour memory and the per-LED output pipeline.
`default_nettype none

module led_fx_back (
    input  wire                 clk,
    input  wire                 rst_n,
    input  led_fx_pkg::cfg_t    cfg,
    input  wire                 step_clear,
    input  wire                 queue_empty,
    input  led_fx_pkg::cmd_t    queue_cmd,
    output logic                pop,
    output logic                out_valid,
    input  wire                 out_stall,
    output logic [5:0]          led_number,
    output logic [7:0]          green_out,
    output logic [7:0]          red_out,
    output logic [7:0]          blue_out,
    output logic                last_of_frame
);
    import led_fx_pkg::*;

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_WALK = 1'b1;

    logic              state_reg;
    logic              state_next;
    logic [ADDR_W-1:0] cnt_reg;
    logic [ADDR_W-1:0] cnt_next;
    cmd_t              cmd_reg;

    // Effect state
    logic [7:0] step_reg;
    logic [7:0] step_next;
    logic [7:0] fade_level_reg;
    logic [7:0] fade_level_next;
    logic       fade_falling_reg;
    logic       fade_falling_next;
    logic [7:0] breathe_level_reg;
    logic [7:0] breathe_level_next;
    logic       breathe_falling_reg;
    logic       breathe_falling_next;
    logic [5:0] scan_pos_reg;
    logic [5:0] scan_pos_next;
    logic       scan_back_reg;
    logic       scan_back_next;
    logic       chase_phase_reg;
    logic       chase_phase_next;

    // Per-frame values captured when a command starts
    logic [7:0] f_level_reg;
    logic [7:0] f_level_next;
    logic [7:0] f_step_reg;
    logic [5:0] f_pos_reg;
    logic       f_phase_reg;

    // Colour memory
    rgb_t               mem [LED_COUNT];
    logic [LED_COUNT-1:0] mem_valid_reg;
    rgb_t               rd_data_reg;
    logic               rd_valid_reg;

    // Read stage
    logic              s1_valid_reg;
    logic [ADDR_W-1:0] s1_index_reg;
    logic              s1_last_reg;
    logic              s1_use_mem_reg;
    rgb_t              s1_alt_reg;
    logic [7:0]        s1_mult_reg;

    // Output stage
    logic       out_valid_reg;
    logic [5:0] led_number_reg;
    logic [7:0] green_reg;
    logic [7:0] red_reg;
    logic [7:0] blue_reg;
    logic       last_reg;

    logic       adv;
    logic       walk_step;
    logic       cnt_last;
    logic       start_advance;
    bounce_t    fade_b;
    bounce_t    breathe_b;
    logic [5:0] scan_step;
    logic [7:0] bright_m;
    logic [7:0] hue;
    logic       walk_use_mem;
    rgb_t       walk_alt;
    logic [7:0] walk_mult;
    rgb_t       s1_colour;

    assign adv           = !out_valid_reg || !out_stall;
    assign pop           = (state_reg == ST_IDLE) && !queue_empty;
    assign walk_step     = (state_reg == ST_WALK) && adv;
    assign cnt_last      = (cnt_reg == ADDR_W'(LED_COUNT - 1));
    assign start_advance = pop && (queue_cmd.op == OP_ADVANCE);
    assign bright_m      = cfg.strip_enabled ? cfg.brightness : 8'd0;

    assign fade_b    = bounce(fade_level_reg, fade_falling_reg, FADE_STEP);
    assign breathe_b = bounce(breathe_level_reg, breathe_falling_reg, BREATHE_STEP);

    always_comb
    begin
        if (scan_back_reg)
        begin
            scan_step = (scan_pos_reg != 6'd0) ? scan_pos_reg - 6'd1 : 6'd0;
        end
        else
        begin
            scan_step = scan_pos_reg + 6'd1;
        end
    end

    // Effect state moves once per effect frame, at the cycle its command starts.
    always_comb
    begin
        step_next            = step_reg;
        fade_level_next      = fade_level_reg;
        fade_falling_next    = fade_falling_reg;
        breathe_level_next   = breathe_level_reg;
        breathe_falling_next = breathe_falling_reg;
        scan_pos_next        = scan_pos_reg;
        scan_back_next       = scan_back_reg;
        chase_phase_next     = chase_phase_reg;
        f_level_next         = 8'd0;
        case (cfg.effect_mode)
            MODE_BLINK:
            begin
                step_next    = (step_reg != 8'd0) ? 8'd0 : 8'd1;
                f_level_next = (step_reg != 8'd0) ? 8'd0 : cfg.brightness;
            end
            MODE_FADE:
            begin
                fade_level_next   = fade_b.level;
                fade_falling_next = fade_b.falling;
                f_level_next      = fade_b.level;
            end
            MODE_RAINBOW:
            begin
                step_next = step_reg + RAINBOW_STEP;
            end
            MODE_BREATHE:
            begin
                breathe_level_next   = breathe_b.level;
                breathe_falling_next = breathe_b.falling;
                f_level_next         = breathe_b.level;
            end
            MODE_SCANNER:
            begin
                scan_pos_next = scan_step;
                if (scan_step == 6'd0)
                begin
                    scan_back_next = 1'b0;
                end
                else if (scan_step >= 6'(LED_COUNT - 1))
                begin
                    scan_back_next = 1'b1;
                end
            end
            MODE_CHASE:
            begin
                chase_phase_next = !chase_phase_reg;
            end
            default:
            begin
                f_level_next = 8'd0;
            end
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        if (pop)
        begin
            state_next = ST_WALK;
            cnt_next   = '0;
        end
        else if (walk_step)
        begin
            cnt_next = cnt_reg + 1'b1;
            if (cnt_last)
            begin
                state_next = ST_IDLE;
            end
        end
    end

    // Colour source and multiplier for the LED being issued.
    always_comb
    begin
        hue          = f_step_reg + (8'(cnt_reg) << 6);
        walk_use_mem = 1'b1;
        walk_alt     = cmd_reg.colour;
        walk_mult    = bright_m;
        case (cmd_reg.op)
            OP_WRITE_ONE:
            begin
                walk_mult = bright_m;
            end
            OP_WRITE_ALL:
            begin
                // The sweep is writing the memory, so take the colour from the request.
                walk_use_mem = 1'b0;
            end
            default:
            begin
                case (cfg.effect_mode)
                    MODE_RAINBOW:
                    begin
                        walk_use_mem = 1'b0;
                        walk_alt     = wheel(hue);
                        walk_mult    = cfg.brightness;
                    end
                    MODE_SCANNER:
                    begin
                        walk_mult = (6'(cnt_reg) == f_pos_reg) ? cfg.brightness : 8'd0;
                    end
                    MODE_CHASE:
                    begin
                        walk_mult = (cnt_reg[0] ^ f_phase_reg) ? 8'd0 : cfg.brightness;
                    end
                    default:
                    begin
                        walk_mult = f_level_reg;
                    end
                endcase
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg           <= ST_IDLE;
            cnt_reg             <= '0;
            step_reg            <= 8'd0;
            fade_level_reg      <= 8'd0;
            fade_falling_reg    <= 1'b0;
            breathe_level_reg   <= 8'd0;
            breathe_falling_reg <= 1'b0;
            scan_pos_reg        <= 6'd0;
            scan_back_reg       <= 1'b0;
            chase_phase_reg     <= 1'b0;
            mem_valid_reg       <= '0;
            rd_valid_reg        <= 1'b0;
            s1_valid_reg        <= 1'b0;
            out_valid_reg       <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            if (step_clear)
            begin
                step_reg <= 8'd0;
            end
            else if (start_advance)
            begin
                step_reg <= step_next;
            end
            if (start_advance)
            begin
                fade_level_reg      <= fade_level_next;
                fade_falling_reg    <= fade_falling_next;
                breathe_level_reg   <= breathe_level_next;
                breathe_falling_reg <= breathe_falling_next;
                scan_pos_reg        <= scan_pos_next;
                scan_back_reg       <= scan_back_next;
                chase_phase_reg     <= chase_phase_next;
            end
            if (pop && (queue_cmd.op == OP_WRITE_ONE))
            begin
                mem_valid_reg[queue_cmd.index] <= 1'b1;
            end
            else if (pop && (queue_cmd.op == OP_WRITE_ALL))
            begin
                mem_valid_reg <= '1;
            end
            if (walk_step)
            begin
                rd_valid_reg <= mem_valid_reg[cnt_reg];
            end
            if (adv)
            begin
                s1_valid_reg  <= walk_step;
                out_valid_reg <= s1_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            cmd_reg     <= queue_cmd;
            f_level_reg <= f_level_next;
            f_step_reg  <= step_reg;
            f_pos_reg   <= scan_pos_reg;
            f_phase_reg <= chase_phase_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop && (queue_cmd.op == OP_WRITE_ONE))
        begin
            mem[queue_cmd.index] <= queue_cmd.colour;
        end
        else if (walk_step && (cmd_reg.op == OP_WRITE_ALL))
        begin
            mem[cnt_reg] <= cmd_reg.colour;
        end
        if (walk_step)
        begin
            rd_data_reg <= mem[cnt_reg];
        end
    end

    always_ff @(posedge clk)
    begin
        if (walk_step)
        begin
            s1_index_reg   <= cnt_reg;
            s1_last_reg    <= cnt_last;
            s1_use_mem_reg <= walk_use_mem;
            s1_alt_reg     <= walk_alt;
            s1_mult_reg    <= walk_mult;
        end
    end

    // Entries never written read as black.
    always_comb
    begin
        if (s1_use_mem_reg)
        begin
            s1_colour = rd_valid_reg ? rd_data_reg : '0;
        end
        else
        begin
            s1_colour = s1_alt_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv && s1_valid_reg)
        begin
            led_number_reg <= 6'(s1_index_reg);
            green_reg      <= scale8(s1_colour.green, s1_mult_reg);
            red_reg        <= scale8(s1_colour.red, s1_mult_reg);
            blue_reg       <= scale8(s1_colour.blue, s1_mult_reg);
            last_reg       <= s1_last_reg;
        end
    end

    assign out_valid     = out_valid_reg;
    assign led_number    = led_number_reg;
    assign green_out     = green_reg;
    assign red_out       = red_reg;
    assign blue_out      = blue_reg;
    assign last_of_frame = last_reg;

endmodule

`default_nettype wire

@@ rtl/led_strip_effect_engine_top.sv @@
// Top level of the LED strip effect engine: configuration registers and the two halves.
//
//   Channel  Direction  Handshake              Payload
//   in       input      in_valid / in_stall    kind, led_index, red_in, green_in, blue_in
//   out      output     out_valid / out_stall  led_number, green_out, red_out, blue_out,
//                                              last_of_frame
//   cfg      input      cfg_we                 cfg_index, cfg_data
//
// A request is classified in the cycle it is accepted; one that makes a frame is queued.
// A generator frame is a command pop and a walk of the LEDs, one LED per cycle unless the
// output stalls, from the colour memory's single read port, through the read and output stages.
// Reset clears all control and effect state at once; there is no clearing pass.
// A stall on the output holds the pipeline; a full queue stalls the input.
`default_nettype none

module led_strip_effect_engine_top (
    input  wire                          clk,
    input  wire                          rst_n,
    input  wire                          in_valid,
    output logic                         in_stall,
    input  wire  [1:0]                   kind,
    input  wire  [7:0]                   led_index,
    input  wire  [7:0]                   red_in,
    input  wire  [7:0]                   green_in,
    input  wire  [7:0]                   blue_in,
    output logic                         out_valid,
    input  wire                          out_stall,
    output logic [5:0]                   led_number,
    output logic [7:0]                   green_out,
    output logic [7:0]                   red_out,
    output logic [7:0]                   blue_out,
    output logic                         last_of_frame,
    input  wire                          cfg_we,
    input  wire  [led_fx_pkg::REG_W-1:0] cfg_index,
    input  wire  [7:0]                   cfg_data
);
    import led_fx_pkg::*;

    logic [7:0] brightness_reg;
    logic [2:0] effect_mode_reg;
    logic [3:0] effect_speed_reg;
    logic       strip_enabled_reg;
    cfg_t       cfg;
    logic       step_clear;
    logic       push;
    cmd_t       push_cmd;
    logic       queue_full;
    logic       queue_empty;
    logic       pop;
    cmd_t       queue_cmd;

    assign cfg.brightness    = brightness_reg;
    assign cfg.effect_mode   = effect_mode_reg;
    assign cfg.effect_speed  = effect_speed_reg;
    assign cfg.strip_enabled = strip_enabled_reg;

    // Selecting an effect restarts its step counter.
    assign step_clear = cfg_we && (cfg_index == REG_EFFECT_MODE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            brightness_reg    <= 8'd255;
            effect_mode_reg   <= MODE_STATIC;
            effect_speed_reg  <= 4'd5;
            strip_enabled_reg <= 1'b1;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_BRIGHTNESS:    brightness_reg    <= cfg_data;
                REG_EFFECT_MODE:   effect_mode_reg   <= cfg_data[2:0];
                REG_EFFECT_SPEED:  effect_speed_reg  <= cfg_data[3:0];
                REG_STRIP_ENABLED: strip_enabled_reg <= cfg_data[0];
                default:           brightness_reg    <= brightness_reg;
            endcase
        end
    end

    led_fx_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .kind       (kind),
        .led_index  (led_index),
        .red_in     (red_in),
        .green_in   (green_in),
        .blue_in    (blue_in),
        .push       (push),
        .push_cmd   (push_cmd),
        .queue_full (queue_full)
    );

    led_fx_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .full     (queue_full),
        .pop      (pop),
        .pop_cmd  (queue_cmd),
        .empty    (queue_empty)
    );

    led_fx_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg),
        .step_clear    (step_clear),
        .queue_empty   (queue_empty),
        .queue_cmd     (queue_cmd),
        .pop           (pop),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .led_number    (led_number),
        .green_out     (green_out),
        .red_out       (red_out),
        .blue_out      (blue_out),
        .last_of_frame (last_of_frame)
    );

endmodule

`default_nettype wire

@@ rtl/led_fx_checker.sv @@
// Port-level checks on the LED strip effect engine output, bound to the top level.
`default_nettype none

module led_fx_checker (
    input wire       clk,
    input wire       rst_n,
    input wire       out_valid,
    input wire       out_stall,
    input wire [5:0] led_number,
    input wire [7:0] green_out,
    input wire [7:0] red_out,
    input wire [7:0] blue_out,
    input wire       last_of_frame
);
    import led_fx_pkg::*;

    a_valid_held: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("output request dropped while stalled");

    a_payload_held: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(led_number) && $stable(green_out)
            && $stable(red_out) && $stable(blue_out) && $stable(last_of_frame))
        else $error("output payload changed while stalled");

    a_last_position: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && last_of_frame |-> led_number == 6'(LED_COUNT - 1))
        else $error("frame end marked on the wrong LED");

    a_led_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> led_number <= 6'(LED_COUNT - 1))
        else $error("LED number beyond the strip");

    a_quiet_after_reset: assert property (@(posedge clk)
        !rst_n |=> !out_valid)
        else $error("output request right after reset");

endmodule

bind led_strip_effect_engine_top led_fx_checker u_checker (.*);

`default_nettype wire

@@ dv/testbench.sv @@
// Self-checking testbench for the LED strip effect engine, with its own frame predictor.
`timescale 1ns / 1ps

module testbench;

    import led_fx_pkg::*;

    localparam logic [1:0] KIND_UNUSED     = 2'd3;
    localparam int         CLOCK_HALF      = 5;
    localparam int         RESET_CYCLES    = 7;
    localparam int         MAX_WAIT        = 19;
    localparam int         SETTLE_CYCLES   = 2 * (LED_COUNT + 4);
    localparam int         WATCHDOG_LIMIT  = 2000;
    localparam int         RANDOM_REQUESTS = 125;
    localparam int         FADE_DELTA      = 10;
    localparam int         BREATHE_DELTA   = 5;
    localparam int         HUE_STEP        = 5;
    localparam int         HUE_PER_LED     = 64;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] index;
        rgb_t       colour;
    } request_t;

    typedef struct packed {
        logic [5:0] number;
        logic [7:0] green;
        logic [7:0] red;
        logic [7:0] blue;
        logic       last;
    } led_result_t;

    // One line of the directed table: a register write or a request, where a request may
    // carry a literal outcome (no LEDs at all, or one colour on every LED).
    typedef struct {
        bit         is_reg;
        logic [1:0] reg_index;
        logic [7:0] reg_data;
        request_t   rq;
        bit         literal;
        bit         literal_frame;
        rgb_t       literal_colour;
    } step_row_t;

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 in_valid  = 1'b0;
    logic [1:0]           kind      = KIND_TICK;
    logic [7:0]           led_index = 8'd0;
    logic [7:0]           red_in    = 8'd0;
    logic [7:0]           green_in  = 8'd0;
    logic [7:0]           blue_in   = 8'd0;
    logic                 out_stall = 1'b0;
    logic                 cfg_we    = 1'b0;
    logic [REG_W-1:0]     cfg_index = REG_BRIGHTNESS;
    logic [7:0]           cfg_data  = 8'd0;
    wire                  in_stall;
    wire                  out_valid;
    wire  [5:0]           led_number;
    wire  [7:0]           green_out;
    wire  [7:0]           red_out;
    wire  [7:0]           blue_out;
    wire                  last_of_frame;

    // Predicted state of the strip, starting from its reset values.
    rgb_t                 colours [LED_COUNT] = '{default: '0};
    logic [7:0]           brightness_setting = 8'd255;
    logic [2:0]           mode_setting       = MODE_STATIC;
    logic [3:0]           speed_setting      = 4'd5;
    logic                 strip_on           = 1'b1;
    logic [6:0]           ticks              = '0;
    logic [7:0]           steps              = '0;
    logic [7:0]           fade               = '0;
    logic                 fade_down          = 1'b0;
    logic [7:0]           breath             = '0;
    logic                 breath_down        = 1'b0;
    logic [5:0]           scan_pos           = '0;
    logic                 scan_back          = 1'b0;
    logic                 chase_odd          = 1'b0;

    led_result_t          frame_buf [LED_COUNT];
    int                   frame_len;
    led_result_t          expected_leds [$];
    step_row_t            directed_steps [$];

    int                   errors          = 0;
    int                   requests_sent   = 0;
    int                   results_checked = 0;
    int                   reg_writes      = 0;
    int                   idle_cycles     = 0;
    bit                   sender_busy     = 1'b1;
    bit                   receiver_busy   = 1'b1;

    led_strip_effect_engine_top dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .kind          (kind),
        .led_index     (led_index),
        .red_in        (red_in),
        .green_in      (green_in),
        .blue_in       (blue_in),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .led_number    (led_number),
        .green_out     (green_out),
        .red_out       (red_out),
        .blue_out      (blue_out),
        .last_of_frame (last_of_frame),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    initial
    begin
        forever #CLOCK_HALF clk = ~clk;
    end

    initial
    begin
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
    end

    function automatic int draw_wait(bit busy);
        return busy ? $urandom_range(0, MAX_WAIT) : 0;
    endfunction

    // ---------------------------------------------------------------- predictor

    function automatic logic [7:0] scaled(logic [7:0] c, logic [7:0] m);
        int unsigned p;
        p = c * m;
        p = p / 255;
        return p[7:0];
    endfunction

    function automatic void set_led(int i, rgb_t c, logic [7:0] m);
        frame_buf[i].number = 6'(i);
        frame_buf[i].green  = scaled(c.green, m);
        frame_buf[i].red    = scaled(c.red, m);
        frame_buf[i].blue   = scaled(c.blue, m);
        frame_buf[i].last   = (i == LED_COUNT - 1);
    endfunction

    function automatic void show_stored(logic [7:0] m);
        for (int i = 0; i < LED_COUNT; i++)
            set_led(i, colours[i], m);
        frame_len = LED_COUNT;
    endfunction

    // Returns {falling, level} after one move; the level sticks at 0 and 255 and turns there.
    function automatic logic [8:0] step_level(logic [7:0] level, logic down, int delta);
        int v;
        v = down ? int'(level) - delta : int'(level) + delta;
        if (v >= 255)
        begin
            v    = 255;
            down = 1'b1;
        end
        if (v <= 0)
        begin
            v    = 0;
            down = 1'b0;
        end
        return {down, 8'(v)};
    endfunction

    function automatic rgb_t hue_colour(logic [7:0] hue);
        rgb_t c;
        int   h;
        h = hue;
        if (h < 85)
        begin
            c.red   = 8'(3 * h);
            c.green = 8'(255 - 3 * h);
            c.blue  = 8'd0;
        end
        else if (h < 170)
        begin
            h       = h - 85;
            c.red   = 8'(255 - 3 * h);
            c.green = 8'd0;
            c.blue  = 8'(3 * h);
        end
        else
        begin
            h       = h - 170;
            c.red   = 8'd0;
            c.green = 8'(3 * h);
            c.blue  = 8'(255 - 3 * h);
        end
        return c;
    endfunction

    function automatic void advance_effect();
        frame_len = LED_COUNT;
        case (mode_setting)
            MODE_BLINK:
            begin
                steps = (steps != 8'd0) ? 8'd0 : 8'd1;
                show_stored((steps != 8'd0) ? brightness_setting : 8'd0);
            end
            MODE_FADE:
            begin
                {fade_down, fade} = step_level(fade, fade_down, FADE_DELTA);
                show_stored(fade);
            end
            MODE_RAINBOW:
            begin
                for (int i = 0; i < LED_COUNT; i++)
                    set_led(i, hue_colour(8'(steps + HUE_PER_LED * i)), brightness_setting);
                steps = 8'(steps + HUE_STEP);
            end
            MODE_BREATHE:
            begin
                {breath_down, breath} = step_level(breath, breath_down, BREATHE_DELTA);
                show_stored(breath);
            end
            MODE_SCANNER:
            begin
                for (int i = 0; i < LED_COUNT; i++)
                    set_led(i, colours[i], (i == scan_pos) ? brightness_setting : 8'd0);
                if (scan_back)
                begin
                    if (scan_pos > 0)
                        scan_pos = scan_pos - 6'd1;
                end
                else
                begin
                    scan_pos = scan_pos + 6'd1;
                end
                if (scan_pos >= LED_COUNT - 1)
                    scan_back = 1'b1;
                if (scan_pos == 0)
                    scan_back = 1'b0;
            end
            MODE_CHASE:
            begin
                for (int i = 0; i < LED_COUNT; i++)
                    set_led(i, colours[i],
                            (((i + chase_odd) % 2) == 0) ? brightness_setting : 8'd0);
                chase_odd = ~chase_odd;
            end
            default:
            begin
                // Static and the unimplemented random effect leave the strip alone.
                frame_len = 0;
            end
        endcase
    endfunction

    // Works out the LEDs that one accepted request produces, in frame_buf / frame_len.
    function automatic void predict_request(request_t rq);
        int sp;
        frame_len = 0;
        case (rq.kind)
            KIND_TICK:
            begin
                // Ticks on a dark strip are dropped without counting.
                if (strip_on)
                begin
                    sp = speed_setting;
                    if (sp < 1)
                        sp = 1;
                    if (sp > 10)
                        sp = 10;
                    ticks = ticks + 7'd1;
                    if (ticks >= 100 - 10 * sp)
                    begin
                        ticks = '0;
                        advance_effect();
                    end
                end
            end
            KIND_WRITE_ONE:
            begin
                if (rq.index < LED_COUNT)
                begin
                    colours[rq.index] = rq.colour;
                    show_stored(strip_on ? brightness_setting : 8'd0);
                end
            end
            KIND_WRITE_ALL:
            begin
                for (int i = 0; i < LED_COUNT; i++)
                    colours[i] = rq.colour;
                show_stored(strip_on ? brightness_setting : 8'd0);
            end
            default:
            begin
            end
        endcase
    endfunction

    function automatic void apply_reg(logic [1:0] index, logic [7:0] data);
        case (index)
            REG_BRIGHTNESS:
                brightness_setting = data;
            REG_EFFECT_MODE:
            begin
                mode_setting = data[2:0];
                steps        = '0;
            end
            REG_EFFECT_SPEED:
                speed_setting = data[3:0];
            REG_STRIP_ENABLED:
                strip_on = data[0];
            default:
            begin
            end
        endcase
    endfunction

    function automatic void expect_frame();
        for (int i = 0; i < frame_len; i++)
            expected_leds.push_back(frame_buf[i]);
    endfunction

    // ---------------------------------------------------------------- directed table

    function automatic void add_request(logic [1:0] k, logic [7:0] idx, logic [7:0] r,
                                        logic [7:0] g, logic [7:0] b, bit literal = 1'b0,
                                        bit literal_frame = 1'b0, rgb_t shown = '0);
        step_row_t row;
        row                = '{default: '0};
        row.rq.kind        = k;
        row.rq.index       = idx;
        row.rq.colour      = {r, g, b};
        row.literal        = literal;
        row.literal_frame  = literal_frame;
        row.literal_colour = shown;
        directed_steps.push_back(row);
    endfunction

    function automatic void add_reg(logic [1:0] index, logic [7:0] data);
        step_row_t row;
        row           = '{default: '0};
        row.is_reg    = 1'b1;
        row.reg_index = index;
        row.reg_data  = data;
        directed_steps.push_back(row);
    endfunction

    // ---------------------------------------------------------------- drivers

    task automatic send_request(request_t rq);
        int gap;
        gap = draw_wait(sender_busy);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid  <= 1'b1;
        kind      <= rq.kind;
        led_index <= rq.index;
        red_in    <= rq.colour.red;
        green_in  <= rq.colour.green;
        blue_in   <= rq.colour.blue;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        requests_sent++;
    endtask

    task automatic take_request(request_t rq);
        send_request(rq);
        predict_request(rq);
        expect_frame();
    endtask

    task automatic write_reg(logic [1:0] index, logic [7:0] data);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= index;
        cfg_data  <= data;
        @(posedge clk);
        cfg_we <= 1'b0;
        apply_reg(index, data);
        reg_writes++;
    endtask

    // Lets the block run dry: every expected LED out, then time for a tick in flight.
    task automatic settle();
        in_valid <= 1'b0;
        while (expected_leds.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // The receiver holds off for a random number of cycles before each LED.
    initial
    begin
        int hold;
        forever
        begin
            hold = draw_wait(receiver_busy);
            if (hold > 0)
            begin
                out_stall <= 1'b1;
                repeat (hold) @(posedge clk);
                out_stall <= 1'b0;
            end
            @(posedge clk);
            while (!out_valid)
                @(posedge clk);
        end
    end

    // ---------------------------------------------------------------- checking

    function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            errors++;
        end
    endfunction

    always @(posedge clk)
    begin
        led_result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_leds.size() == 0)
            begin
                $error("LED %0d arrived with nothing expected", led_number);
                errors++;
            end
            else
            begin
                want = expected_leds.pop_front();
                check_field("led_number", 8'(want.number), 8'(led_number));
                check_field("green_out", want.green, green_out);
                check_field("red_out", want.red, red_out);
                check_field("blue_out", want.blue, blue_out);
                check_field("last_of_frame", 8'(want.last), 8'(last_of_frame));
                results_checked++;
            end
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles == WATCHDOG_LIMIT)
        begin
            $display("Watchdog: nothing moved for %0d cycles", WATCHDOG_LIMIT);
            $display("testbench NOT OK");
            $finish;
        end
    end

    // ---------------------------------------------------------------- stimulus

    initial
    begin
        step_row_t row;
        request_t  rq;
        int        directed_count;
        int        phase;
        int        phase_len;
        int        tick_share;
        int        sel;
        int        speed;

        // Colour writes at reset settings, the ignored requests, then every effect.
        add_request(KIND_WRITE_ALL, 8'd0, 8'd255, 8'd255, 8'd255, 1'b1, 1'b1,
                    {8'd255, 8'd255, 8'd255});
        add_request(KIND_WRITE_ALL, 8'hFF, 8'd0, 8'd0, 8'd0, 1'b1, 1'b1, '0);
        add_request(KIND_WRITE_ONE, 8'd0, 8'd255, 8'd0, 8'd0);
        add_request(KIND_WRITE_ONE, 8'd3, 8'd0, 8'd255, 8'd0);
        add_request(KIND_WRITE_ONE, 8'd1, 8'h55, 8'hAA, 8'h0F);
        add_request(KIND_WRITE_ONE, 8'd2, 8'hAA, 8'h55, 8'hF0);
        add_request(KIND_WRITE_ONE, 8'd4, 8'd1, 8'd2, 8'd3, 1'b1);
        add_request(KIND_WRITE_ONE, 8'd255, 8'd255, 8'd255, 8'd255, 1'b1);
        add_request(KIND_UNUSED, 8'd0, 8'd255, 8'd255, 8'd255, 1'b1);
        add_request(KIND_TICK, 8'd0, 8'd0, 8'd0, 8'd0, 1'b1);
        // A speed of 15 saturates to 10, so every tick moves the effect.
        add_reg(REG_EFFECT_SPEED, 8'hFF);
        add_reg(REG_EFFECT_MODE, MODE_BLINK);
        add_request(KIND_TICK, 8'd0, 8'd0, 8'd0, 8'd0);
        add_request(KIND_TICK, 8'd0, 8'd0, 8'd0, 8'd0, 1'b1, 1'b1, '0);
        add_reg(REG_BRIGHTNESS, 8'd0);
        add_request(KIND_WRITE_ALL, 8'd0, 8'd200, 8'd100, 8'd50, 1'b1, 1'b1, '0);
        add_reg(REG_BRIGHTNESS, 8'd128);
        add_request(KIND_WRITE_ONE, 8'd1, 8'hFF, 8'h80, 8'h01);
        add_reg(REG_EFFECT_MODE, MODE_FADE);
        add_request(KIND_TICK, 8'd0, 8'd0, 8'd0, 8'd0);
        add_reg(REG_EFFECT_MODE, MODE_RAINBOW);
        add_request(KIND_TICK, 8'd0, 8'd0, 8'd0, 8'd0);
        add_request(KIND_TICK, 8'd0, 8'd0, 8'd0, 8'd0);
        add_reg(REG_EFFECT_MODE, MODE_BREATHE);
        add_request(KIND_TICK, 8'd0, 8'd0, 8'd0, 8'd0);
        add_reg(REG_EFFECT_MODE, MODE_SCANNER);
        add_request(KIND_TICK, 8'd0, 8'd0, 8'd0, 8'd0);
        add_request(KIND_TICK, 8'd0, 8'd0, 8'd0, 8'd0);
        add_reg(REG_EFFECT_MODE, MODE_CHASE);
        add_request(KIND_TICK, 8'd0, 8'd0, 8'd0, 8'd0);
        add_request(KIND_TICK, 8'd0, 8'd0, 8'd0, 8'd0);
        add_reg(REG_EFFECT_MODE, MODE_RANDOM);
        add_request(KIND_TICK, 8'd0, 8'd0, 8'd0, 8'd0, 1'b1);
        add_reg(REG_STRIP_ENABLED, 8'd0);
        add_request(KIND_TICK, 8'd0, 8'd0, 8'd0, 8'd0, 1'b1);
        add_request(KIND_WRITE_ALL, 8'd0, 8'd9, 8'd9, 8'd9, 1'b1, 1'b1, '0);
        add_reg(REG_STRIP_ENABLED, 8'd1);
        add_reg(REG_BRIGHTNESS, 8'd255);

        @(posedge clk);
        while (!rst_n)
            @(posedge clk);

        foreach (directed_steps[n])
        begin
            row = directed_steps[n];
            if (row.is_reg)
            begin
                settle();
                write_reg(row.reg_index, row.reg_data);
            end
            else if (!row.literal)
            begin
                take_request(row.rq);
            end
            else
            begin
                send_request(row.rq);
                predict_request(row.rq);
                if (row.literal_frame)
                    for (int i = 0; i < LED_COUNT; i++)
                        expected_leds.push_back({6'(i), row.literal_colour.green,
                                                 row.literal_colour.red,
                                                 row.literal_colour.blue,
                                                 1'(i == LED_COUNT - 1)});
            end
        end
        directed_count = requests_sent;

        // Random phases: new settings while idle, then a burst of mixed requests.
        // The first phase runs the slowest speeds long enough to reach an update.
        phase = 0;
        while (requests_sent - directed_count < RANDOM_REQUESTS)
        begin
            settle();
            sender_busy   = ($urandom_range(0, 3) != 0);
            receiver_busy = ($urandom_range(0, 3) != 0);
            sel = $urandom_range(0, 3);
            write_reg(REG_BRIGHTNESS, (sel == 0) ? 8'd0 : (sel == 1) ? 8'd255 : 8'($urandom));
            write_reg(REG_EFFECT_MODE,
                      {5'($urandom), (phase == 0) ? MODE_CHASE : 3'($urandom)});
            if (phase == 0)
                speed = $urandom_range(0, 1);
            else if ($urandom_range(0, 3) == 0)
                speed = $urandom_range(2, 6);
            else
                speed = $urandom_range(7, 15);
            write_reg(REG_EFFECT_SPEED, {4'($urandom), 4'(speed)});
            write_reg(REG_STRIP_ENABLED,
                      {7'($urandom), 1'((phase == 0) || ($urandom_range(0, 7) != 0))});
            phase_len  = (phase == 0) ? 95 : $urandom_range(8, 24);
            tick_share = (phase == 0) ? 100 : 55;
            for (int k = 0; k < phase_len; k++)
            begin
                sel       = $urandom_range(0, 99);
                rq.colour = 24'($urandom);
                rq.index  = 8'($urandom);
                if (sel < tick_share)
                begin
                    rq.kind = KIND_TICK;
                end
                else if (sel < tick_share + 20)
                begin
                    rq.kind = KIND_WRITE_ONE;
                    if ($urandom_range(0, 6) != 0)
                        rq.index = 8'($urandom_range(0, LED_COUNT - 1));
                end
                else if (sel < tick_share + 38)
                begin
                    rq.kind = KIND_WRITE_ALL;
                end
                else
                begin
                    rq.kind = KIND_UNUSED;
                end
                take_request(rq);
            end
            phase++;
        end

        settle();
        $display("Sent %0d requests (%0d directed) with %0d register writes in %0d phases.",
                 requests_sent, directed_count, reg_writes, phase);
        $display("Compared %0d LED results; %0d mismatches found.", results_checked, errors);
        if (errors == 0)
            $display("testbench OK");
        else
            $display("testbench NOT OK");
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/led_fx_pkg.sv
rtl/led_fx_queue.sv
rtl/led_fx_front.sv
rtl/led_fx_back.sv
rtl/led_strip_effect_engine_top.sv
rtl/led_fx_checker.sv
dv/testbench.sv
